// ===== rtl/eth_ipv4_tcp_header_classifier_macros.svh =====
// Assertion macros used by the classifier queue RTL file.
`ifndef ETH_IPV4_TCP_HEADER_CLASSIFIER_MACROS_SVH
`define ETH_IPV4_TCP_HEADER_CLASSIFIER_MACROS_SVH

// Same-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define EITC_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define EITC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/eitc_pkg.sv =====
// Types and constants shared by the Ethernet/IPv4/TCP header classifier.
package eitc_pkg;

    // Maximum number of VLAN or QinQ tags that are skipped ahead of the ethertype.
    localparam logic [1:0]  MAX_TAGS        = 2'd2;

    localparam logic [15:0] TPID_VLAN       = 16'h8100;
    localparam logic [15:0] TPID_QINQ       = 16'h88A8;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [4:0]  ETH_HDR_BYTES   = 5'd14;
    localparam logic [3:0]  IPV4_VERSION    = 4'd4;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [15:0] FRAG_MASK       = 16'h3FFF;
    localparam logic [5:0]  IP_HDR_MIN      = 6'd20;
    localparam logic [5:0]  TCP_HDR_MIN     = 6'd20;
    localparam logic [15:0] TCP_FLAG_FIN    = 16'h0001;
    localparam logic [15:0] TCP_FLAG_SYN    = 16'h0002;
    localparam logic [15:0] TCP_FLAG_RST    = 16'h0004;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_INDEX_W     = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_BYTES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LISTEN_PORT     = 1'd1;
    localparam logic [15:0] MAX_FRAME_RESET = 16'd1522;
    localparam logic [15:0] LISTEN_RESET    = 16'd102;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED = 2'd0,
        VERDICT_IGNORED  = 2'd1,
        VERDICT_MALFORMED = 2'd2,
        VERDICT_FRAGMENT = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [15:0] max_frame_bytes;
        logic [15:0] listen_port;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq_number;
        logic        syn_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [15:0] payload_start;
        logic [15:0] payload_bytes;
    } t_out_item;

    // Header snapshot of one finished frame, handed from the parser to the judge.
    typedef struct packed {
        logic [16:0] frame_len;
        logic [4:0]  ip_start;
        logic [15:0] ether_kind;
        logic [7:0]  version_ihl;
        logic [15:0] ip_total_length;
        logic [15:0] fragment_word;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq_number;
        logic [15:0] offset_and_flags;
    } t_frame_rec;

endpackage

// ===== rtl/eitc_front.sv =====
// Byte-level header parser: tracks the frame position and captures header fields.
module eitc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  eitc_pkg::t_in_item    i_in,
    input  logic                  i_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output eitc_pkg::t_frame_rec  o_rec
);

    logic [15:0] r_pos,   n_pos;
    logic [1:0]  r_tags,  n_tags;
    logic [15:0] r_ether, n_ether;
    logic [4:0]  r_ip_start, n_ip_start;
    logic [7:0]  r_vihl,  n_vihl;
    logic [15:0] r_tot,   n_tot;
    logic [15:0] r_frag,  n_frag;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_addr0, n_addr0;
    logic [31:0] r_addr1, n_addr1;
    logic [15:0] r_port0, n_port0;
    logic [15:0] r_port1, n_port1;
    logic [31:0] r_seq,   n_seq;
    logic [15:0] r_oaf,   n_oaf;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] ip16;
    logic [15:0] rel;
    logic [15:0] trel;
    logic [5:0]  ihl;
    logic        in_ip;
    logic        in_tcp;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign b          = i_in.data_byte;
    assign ip16       = {11'd0, r_ip_start};
    assign rel        = r_pos - ip16;
    assign in_ip      = (r_pos >= ip16);
    assign ihl        = (in_ip && rel == 16'd0) ? {b[3:0], 2'b00} : {r_vihl[3:0], 2'b00};
    assign in_tcp     = in_ip && (rel >= {10'd0, ihl});
    assign trel       = rel - {10'd0, ihl};

    always_comb begin
        n_pos      = (r_pos != 16'hFFFF) ? r_pos + 16'd1 : r_pos;
        n_tags     = r_tags;
        n_ether    = r_ether;
        n_ip_start = r_ip_start;
        n_vihl     = r_vihl;
        n_tot      = r_tot;
        n_frag     = r_frag;
        n_proto    = r_proto;
        n_addr0    = r_addr0;
        n_addr1    = r_addr1;
        n_port0    = r_port0;
        n_port1    = r_port1;
        n_seq      = r_seq;
        n_oaf      = r_oaf;

        // Ethertype (or tag protocol id) sits in the two bytes before the IP start.
        if (r_pos == ip16 - 16'd2) begin
            n_ether = {b, r_ether[7:0]};
        end
        if (r_pos == ip16 - 16'd1) begin
            n_ether = {r_ether[15:8], b};
            if ((n_ether == eitc_pkg::TPID_VLAN || n_ether == eitc_pkg::TPID_QINQ)
                    && r_tags < eitc_pkg::MAX_TAGS) begin
                n_tags     = r_tags + 2'd1;
                n_ip_start = r_ip_start + 5'd4;
            end
        end

        if (in_ip) begin
            if (rel == 16'd0) begin
                n_vihl = b;
            end else if (rel == 16'd2 || rel == 16'd3) begin
                n_tot = {r_tot[7:0], b};
            end else if (rel == 16'd6 || rel == 16'd7) begin
                n_frag = {r_frag[7:0], b};
            end else if (rel == 16'd9) begin
                n_proto = b;
            end else if (rel >= 16'd12 && rel < 16'd16) begin
                n_addr0 = {r_addr0[23:0], b};
            end else if (rel >= 16'd16 && rel < 16'd20) begin
                n_addr1 = {r_addr1[23:0], b};
            end
        end

        // The TCP header follows the IP header; with a zero IHL the two overlap.
        if (in_tcp) begin
            if (trel < 16'd2) begin
                n_port0 = {r_port0[7:0], b};
            end else if (trel < 16'd4) begin
                n_port1 = {r_port1[7:0], b};
            end else if (trel < 16'd8) begin
                n_seq = {r_seq[23:0], b};
            end else if (trel == 16'd12 || trel == 16'd13) begin
                n_oaf = {r_oaf[7:0], b};
            end
        end
    end

    always_comb begin
        o_push                 = accept && i_in.last_byte;
        o_rec.frame_len        = {1'b0, r_pos} + 17'd1;
        o_rec.ip_start         = n_ip_start;
        o_rec.ether_kind       = n_ether;
        o_rec.version_ihl      = n_vihl;
        o_rec.ip_total_length  = n_tot;
        o_rec.fragment_word    = n_frag;
        o_rec.ip_protocol      = n_proto;
        o_rec.source_ip        = n_addr0;
        o_rec.dest_ip          = n_addr1;
        o_rec.source_port      = n_port0;
        o_rec.dest_port        = n_port1;
        o_rec.seq_number       = n_seq;
        o_rec.offset_and_flags = n_oaf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.last_byte)) begin
            r_pos      <= '0;
            r_tags     <= '0;
            r_ether    <= '0;
            r_ip_start <= eitc_pkg::ETH_HDR_BYTES;
            r_vihl     <= '0;
            r_tot      <= '0;
            r_frag     <= '0;
            r_proto    <= '0;
            r_addr0    <= '0;
            r_addr1    <= '0;
            r_port0    <= '0;
            r_port1    <= '0;
            r_seq      <= '0;
            r_oaf      <= '0;
        end else if (accept) begin
            r_pos      <= n_pos;
            r_tags     <= n_tags;
            r_ether    <= n_ether;
            r_ip_start <= n_ip_start;
            r_vihl     <= n_vihl;
            r_tot      <= n_tot;
            r_frag     <= n_frag;
            r_proto    <= n_proto;
            r_addr0    <= n_addr0;
            r_addr1    <= n_addr1;
            r_port0    <= n_port0;
            r_port1    <= n_port1;
            r_seq      <= n_seq;
            r_oaf      <= n_oaf;
        end
    end

endmodule

// ===== rtl/eitc_queue.sv =====
// Small FIFO of finished-frame header snapshots between the parser and the judge.
`include "eth_ipv4_tcp_header_classifier_macros.svh"

module eitc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  eitc_pkg::t_frame_rec  i_rec,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output eitc_pkg::t_frame_rec  o_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    eitc_pkg::t_frame_rec r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `EITC_CHECK(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "queue count above depth")
    `EITC_CHECK(a_no_pop_empty, i_pop, o_valid, "pop from empty queue")
    `EITC_CHECK(a_no_push_full, i_push, !o_full, "push into full queue")
    `EITC_CHECK_NEXT(a_push_shows, i_push && !i_pop, o_valid, "pushed entry not visible")

endmodule

// ===== rtl/eitc_back.sv =====
// Verdict judge: applies the header checks to one snapshot and registers the result.
module eitc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  eitc_pkg::t_cfg        i_cfg,
    input  logic                  i_rec_valid,
    input  eitc_pkg::t_frame_rec  i_rec,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output eitc_pkg::t_out_item   o_out
);

    logic                r_out_valid;
    eitc_pkg::t_out_item r_out;
    eitc_pkg::t_out_item n_out;
    eitc_pkg::t_verdict  verdict;

    logic [16:0] ip17;
    logic [5:0]  ihl;
    logic [5:0]  doff;
    logic [16:0] iplen;
    logic [15:0] tcplen;

    assign ip17   = {12'd0, i_rec.ip_start};
    assign ihl    = {i_rec.version_ihl[3:0], 2'b00};
    assign doff   = {i_rec.offset_and_flags[15:12], 2'b00};
    assign iplen  = i_rec.frame_len - ip17;
    assign tcplen = i_rec.ip_total_length - {10'd0, ihl};

    // The checks run in a fixed order; the first one that fires decides.
    always_comb begin
        priority if (i_rec.frame_len < 17'd14
                || i_rec.frame_len > {1'b0, i_cfg.max_frame_bytes}) begin
            verdict = eitc_pkg::VERDICT_MALFORMED;
        end else if (i_rec.frame_len < ip17) begin
            verdict = eitc_pkg::VERDICT_MALFORMED;
        end else if (i_rec.ether_kind != eitc_pkg::ETHERTYPE_IPV4) begin
            verdict = eitc_pkg::VERDICT_IGNORED;
        end else if (i_rec.frame_len < ip17 + 17'(eitc_pkg::IP_HDR_MIN)) begin
            verdict = eitc_pkg::VERDICT_MALFORMED;
        end else if (i_rec.version_ihl[7:4] != eitc_pkg::IPV4_VERSION) begin
            verdict = eitc_pkg::VERDICT_IGNORED;
        end else if (ihl < eitc_pkg::IP_HDR_MIN || iplen < {11'd0, ihl}) begin
            verdict = eitc_pkg::VERDICT_MALFORMED;
        end else if (i_rec.ip_total_length < {10'd0, ihl}
                || iplen < {1'b0, i_rec.ip_total_length}) begin
            verdict = eitc_pkg::VERDICT_MALFORMED;
        end else if (i_rec.ip_protocol != eitc_pkg::PROTO_TCP) begin
            verdict = eitc_pkg::VERDICT_IGNORED;
        end else if ((i_rec.fragment_word & eitc_pkg::FRAG_MASK) != 16'd0) begin
            verdict = eitc_pkg::VERDICT_FRAGMENT;
        end else if (tcplen < 16'(eitc_pkg::TCP_HDR_MIN)) begin
            verdict = eitc_pkg::VERDICT_MALFORMED;
        end else if (i_rec.source_port != i_cfg.listen_port
                && i_rec.dest_port != i_cfg.listen_port) begin
            verdict = eitc_pkg::VERDICT_IGNORED;
        end else if (doff < eitc_pkg::TCP_HDR_MIN || {10'd0, doff} > tcplen) begin
            verdict = eitc_pkg::VERDICT_MALFORMED;
        end else begin
            verdict = eitc_pkg::VERDICT_ACCEPTED;
        end
    end

    always_comb begin
        n_out         = '0;
        n_out.verdict = verdict;
        if (verdict == eitc_pkg::VERDICT_ACCEPTED) begin
            n_out.source_ip     = i_rec.source_ip;
            n_out.dest_ip       = i_rec.dest_ip;
            n_out.source_port   = i_rec.source_port;
            n_out.dest_port     = i_rec.dest_port;
            n_out.seq_number    = i_rec.seq_number;
            n_out.syn_flag      = (i_rec.offset_and_flags & eitc_pkg::TCP_FLAG_SYN) != 16'd0;
            n_out.fin_flag      = (i_rec.offset_and_flags & eitc_pkg::TCP_FLAG_FIN) != 16'd0;
            n_out.rst_flag      = (i_rec.offset_and_flags & eitc_pkg::TCP_FLAG_RST) != 16'd0;
            n_out.payload_start = {11'd0, i_rec.ip_start} + {10'd0, ihl} + {10'd0, doff};
            n_out.payload_bytes = tcplen - {10'd0, doff};
        end
    end

    assign o_pop       = i_rec_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= i_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/eth_ipv4_tcp_header_classifier.sv =====
// Top level of the Ethernet/IPv4/TCP header classifier.
//
// The block takes an Ethernet frame one byte per transfer, starting at the
// destination MAC, with the final byte flagged by last_byte. It skips up to
// two VLAN (0x8100) or QinQ (0x88A8) tags and gives exactly one result
// transfer per frame, carrying a verdict (accepted, ignored, malformed, or
// dropped as an IPv4 fragment) and, for accepted frames only, the IPv4
// addresses, TCP ports, sequence number, SYN/FIN/RST flags, payload offset
// and payload length; every other field is zero. A frame is accepted only if
// its source or destination port matches the listen_port register. The input
// side takes one byte every clock cycle while the snapshot queue is not full.
// A byte-level parser on the front captures header fields at line rate and,
// at the last byte, pushes a header snapshot into a QUEUE_DEPTH-entry queue.
// A judge on the back applies the checks to the oldest snapshot and loads
// the verdict into an output register whenever that register is empty or
// not stalled, so a stalled output holds only the queue; input stall rises
// only while the queue is full of frames whose verdicts are pending.
// Configuration registers (index 0 max_frame_bytes, index 1 listen_port) are
// written through a simple write port and should be changed only while no
// frame is in flight.
module eth_ipv4_tcp_header_classifier #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  eitc_pkg::t_in_item                    i_in,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output eitc_pkg::t_out_item                   o_out,

    input  logic                                  i_cfg_we,
    input  logic [eitc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [15:0]                           i_cfg_data
);

    eitc_pkg::t_cfg       r_cfg;
    eitc_pkg::t_frame_rec push_rec;
    eitc_pkg::t_frame_rec head_rec;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 head_valid;

    // Configuration registers. Both register indexes are decoded; a write
    // simply replaces the whole register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_bytes <= eitc_pkg::MAX_FRAME_RESET;
            r_cfg.listen_port     <= eitc_pkg::LISTEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eitc_pkg::CFG_MAX_FRAME_BYTES: begin
                    r_cfg.max_frame_bytes <= i_cfg_data;
                end
                eitc_pkg::CFG_LISTEN_PORT: begin
                    r_cfg.listen_port <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front: per-byte parser. It never waits on the output side directly,
    // only on free room in the snapshot queue.
    eitc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_rec      (push_rec)
    );

    // Queue of header snapshots that decouples the parser from the judge.
    eitc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_rec   (head_rec)
    );

    // Back: verdict logic and the registered result transfer.
    eitc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec_valid (head_valid),
        .i_rec       (head_rec),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
